[src/accumulator_cpu_8bit_step_defines.svh]
// assertion macros shared by the accumulator cpu rtl
`ifndef ACCUMULATOR_CPU_8BIT_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_8BIT_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ACC8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ACC8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/acc8_pkg.sv]
// types, opcodes, decoder and alu function for the accumulator cpu
package acc8_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  typedef logic [7:0]       byte_t;
  typedef logic [AddrW-1:0] addr_t;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_EXEC    = 2'd3
  } oper_e;

  // configuration register index
  localparam logic [0:0] REG_START = 1'b0;

  // instruction opcodes
  localparam byte_t OPC_LOAD_IMM  = 8'h00;
  localparam byte_t OPC_LOAD_DIR  = 8'h40;
  localparam byte_t OPC_LOAD_IND  = 8'hC0;
  localparam byte_t OPC_STORE_DIR = 8'h48;
  localparam byte_t OPC_STORE_IND = 8'hC8;
  localparam byte_t OPC_ADD_IMM   = 8'h20;
  localparam byte_t OPC_ADD_DIR   = 8'h60;
  localparam byte_t OPC_ADD_IND   = 8'hE0;
  localparam byte_t OPC_SUB_IMM   = 8'h21;
  localparam byte_t OPC_SUB_DIR   = 8'h61;
  localparam byte_t OPC_SUB_IND   = 8'hE1;
  localparam byte_t OPC_NAND_IMM  = 8'h22;
  localparam byte_t OPC_NAND_DIR  = 8'h62;
  localparam byte_t OPC_NAND_IND  = 8'hE2;
  localparam byte_t OPC_JUMP      = 8'h10;
  localparam byte_t OPC_BRN       = 8'h11;
  localparam byte_t OPC_BRZ       = 8'h12;
  localparam byte_t OPC_IN_DIR    = 8'h49;
  localparam byte_t OPC_IN_IND    = 8'hC9;
  localparam byte_t OPC_OUT_DIR   = 8'h41;
  localparam byte_t OPC_OUT_IND   = 8'hC1;

  typedef enum logic [3:0] {
    K_LOAD, K_STORE, K_ADD, K_SUB, K_NAND,
    K_JUMP, K_BRN, K_BRZ, K_IN, K_OUT, K_BAD
  } kind_e;

  // how many memory hops follow the operand byte to reach the working value
  typedef enum logic [1:0] {
    M_IMM,
    M_DIR,
    M_IND
  } mode_e;

  typedef struct packed {
    kind_e kind;
    mode_e mode;
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_F_OP,
    S_F_ARG,
    S_F_DIR,
    S_F_IND,
    S_EXEC,
    S_FIN
  } state_e;

  // one access on the memory port
  typedef struct packed {
    logic  we;
    addr_t addr;
    byte_t wdata;
  } mem_req_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic  bad_opcode;
    logic  halted;
    logic  in_taken;
    byte_t out_data;
    logic  out_valid;
    byte_t read_data;
    byte_t accumulator;
    byte_t program_counter;
  } res_t;

  // for store and in, the working value is the target address
  function automatic dec_t decode(input byte_t opc);
    dec_t d;
    d.kind = K_BAD;
    d.mode = M_IMM;
    unique case (opc)
      OPC_LOAD_IMM:  d = '{K_LOAD,  M_IMM};
      OPC_LOAD_DIR:  d = '{K_LOAD,  M_DIR};
      OPC_LOAD_IND:  d = '{K_LOAD,  M_IND};
      OPC_STORE_DIR: d = '{K_STORE, M_IMM};
      OPC_STORE_IND: d = '{K_STORE, M_DIR};
      OPC_ADD_IMM:   d = '{K_ADD,   M_IMM};
      OPC_ADD_DIR:   d = '{K_ADD,   M_DIR};
      OPC_ADD_IND:   d = '{K_ADD,   M_IND};
      OPC_SUB_IMM:   d = '{K_SUB,   M_IMM};
      OPC_SUB_DIR:   d = '{K_SUB,   M_DIR};
      OPC_SUB_IND:   d = '{K_SUB,   M_IND};
      OPC_NAND_IMM:  d = '{K_NAND,  M_IMM};
      OPC_NAND_DIR:  d = '{K_NAND,  M_DIR};
      OPC_NAND_IND:  d = '{K_NAND,  M_IND};
      OPC_JUMP:      d = '{K_JUMP,  M_IMM};
      OPC_BRN:       d = '{K_BRN,   M_IMM};
      OPC_BRZ:       d = '{K_BRZ,   M_IMM};
      OPC_IN_DIR:    d = '{K_IN,    M_IMM};
      OPC_IN_IND:    d = '{K_IN,    M_DIR};
      OPC_OUT_DIR:   d = '{K_OUT,   M_DIR};
      OPC_OUT_IND:   d = '{K_OUT,   M_IND};
      default:       d = '{K_BAD,   M_IMM};
    endcase
    return d;
  endfunction

  function automatic byte_t alu(input kind_e kind, input byte_t a, input byte_t b);
    byte_t r;
    unique case (kind)
      K_LOAD:  r = b;
      K_ADD:   r = a + b;
      K_SUB:   r = a - b;
      K_NAND:  r = ~(a & b);
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

[src/acc8_ram.sv]
// 256-byte single-port memory with registered read, reads zero until written
module acc8_ram import acc8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output byte_t    rdata_o
);

  byte_t                 mem_q [MemDepth];
  logic [MemDepth-1:0]   vld_q;
  byte_t                 rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.addr];
  end

  // per-byte valid bits give the all-zero reset image without a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.addr];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

[src/accumulator_cpu_8bit_step.sv]
// top level of the 8-bit accumulator cpu: item sequencer, registers, apb port
//
// Takes one item at a time and returns one result item for it. Memory write
// and restart go straight to the final step, memory read passes one read
// step, and an execute item fetches its opcode and operand byte, then makes
// no memory hop when the operand byte is the working value (immediate, jump,
// branch, direct store and direct in), otherwise one memory hop or two; a
// machine that is halted or in error goes straight to the final step, and
// an unknown opcode stops after the opcode fetch. The sequence is set by the
// single memory port with registered read data, which the sequencer walks
// one access per cycle: opcode, operand, pointer, data, then a write for
// store and in. s_axis_tready is high only while no item is in work; a
// finished result waits in the output register until taken. The memory reads
// as all zero right after reset with no clearing pass.
module accumulator_cpu_8bit_step import acc8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // address[7:0], data[15:8]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // program_counter[7:0], accumulator[15:8], read_data[23:16], out_valid[24],
  // out_data[32:25], in_taken[33], halted[34], bad_opcode[35], zeros[39:36]
  output logic [39:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e   state_q, state_d;
  byte_t    pc_q, pc_d;
  byte_t    acc_q, acc_d;
  logic     halt_q, halt_d;
  logic     err_q, err_d;
  byte_t    start_q;
  kind_e    kind_q, kind_d;
  mode_e    mode_q, mode_d;
  byte_t    val_q, val_d;
  byte_t    data_q, data_d;
  byte_t    rd_q, rd_d;
  logic     ov_q, ov_d;
  byte_t    od_q, od_d;
  logic     it_q, it_d;
  res_t     res_q, res_d;
  logic     tvalid_q, tvalid_d;

  mem_req_t mem_req;
  byte_t    mem_rdata;
  dec_t     dec;
  oper_e    oper;
  addr_t    in_addr;
  byte_t    in_data;
  logic     in_acc;
  logic     out_free;
  logic     cfg_wr;
  byte_t    pc_next;
  byte_t    pc_step;

  assign oper     = oper_e'(s_axis_tuser);
  assign in_addr  = s_axis_tdata[7:0];
  assign in_data  = s_axis_tdata[15:8];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !tvalid_q || m_axis_tready;
  assign dec      = decode(mem_rdata);
  assign pc_step  = pc_q + 8'd2;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = {4'b0, res_q};

  acc8_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // apb port, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START);
  assign prdata = (paddr[2] == REG_START) ? {24'b0, start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_wr) begin
      start_q <= pwdata[7:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (oper)
            OP_WRITE:   state_d = S_FIN;
            OP_READ:    state_d = S_RD;
            OP_RESTART: state_d = S_FIN;
            OP_EXEC:    state_d = (halt_q || err_q) ? S_FIN : S_F_OP;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_RD:    state_d = S_FIN;
      S_F_OP:  state_d = (dec.kind == K_BAD) ? S_FIN : S_F_ARG;
      S_F_ARG: state_d = (mode_q == M_IMM) ? S_EXEC : S_F_DIR;
      S_F_DIR: state_d = (mode_q == M_IND) ? S_F_IND : S_EXEC;
      S_F_IND: state_d = S_EXEC;
      S_EXEC:  state_d = S_FIN;
      S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // branch target or fall-through
  always_comb begin
    unique case (kind_q)
      K_JUMP:  pc_next = val_q;
      K_BRN:   pc_next = acc_q[7] ? val_q : pc_step;
      K_BRZ:   pc_next = (acc_q == 8'd0) ? val_q : pc_step;
      default: pc_next = pc_step;
    endcase
  end

  // datapath and memory port
  always_comb begin
    pc_d     = pc_q;
    acc_d    = acc_q;
    halt_d   = halt_q;
    err_d    = err_q;
    kind_d   = kind_q;
    mode_d   = mode_q;
    val_d    = val_q;
    data_d   = data_q;
    rd_d     = rd_q;
    ov_d     = ov_q;
    od_d     = od_q;
    it_d     = it_q;
    res_d    = res_q;
    tvalid_d = tvalid_q && !m_axis_tready;
    mem_req  = '{we: 1'b0, addr: pc_q, wdata: acc_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          data_d = in_data;
          rd_d   = '0;
          ov_d   = 1'b0;
          od_d   = '0;
          it_d   = 1'b0;
          unique case (oper)
            OP_WRITE:   mem_req = '{we: 1'b1, addr: in_addr, wdata: in_data};
            OP_READ:    mem_req.addr = in_addr;
            OP_RESTART: begin
              pc_d   = start_q;
              halt_d = 1'b0;
              err_d  = 1'b0;
            end
            OP_EXEC:    mem_req.addr = pc_q;
            default:    mem_req.addr = pc_q;
          endcase
        end
      end
      S_RD: rd_d = mem_rdata;
      S_F_OP: begin
        kind_d       = dec.kind;
        mode_d       = dec.mode;
        mem_req.addr = pc_q + 8'd1;
        if (dec.kind == K_BAD) begin
          err_d = 1'b1;
        end
      end
      S_F_ARG, S_F_DIR: begin
        val_d        = mem_rdata;
        mem_req.addr = mem_rdata;
      end
      S_F_IND: val_d = mem_rdata;
      S_EXEC: begin
        acc_d  = alu(kind_q, acc_q, val_q);
        pc_d   = pc_next;
        halt_d = (pc_next == 8'd0);
        if (kind_q == K_STORE) begin
          mem_req = '{we: 1'b1, addr: val_q, wdata: acc_q};
        end
        if (kind_q == K_IN) begin
          mem_req = '{we: 1'b1, addr: val_q, wdata: data_q};
          it_d    = 1'b1;
        end
        if (kind_q == K_OUT) begin
          ov_d = 1'b1;
          od_d = val_q;
        end
      end
      S_FIN: begin
        if (out_free) begin
          tvalid_d = 1'b1;
          res_d    = '{bad_opcode:      err_q,
                       halted:          halt_q,
                       in_taken:        it_q,
                       out_data:        od_q,
                       out_valid:       ov_q,
                       read_data:       rd_q,
                       accumulator:     acc_q,
                       program_counter: pc_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      acc_q    <= '0;
      halt_q   <= 1'b0;
      err_q    <= 1'b0;
      tvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      halt_q   <= halt_d;
      err_q    <= err_d;
      tvalid_q <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    mode_q <= mode_d;
    val_q  <= val_d;
    data_q <= data_d;
    rd_q   <= rd_d;
    ov_q   <= ov_d;
    od_q   <= od_d;
    it_q   <= it_d;
    res_q  <= res_d;
  end

`include "accumulator_cpu_8bit_step_defines.svh"

  `ACC8_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state_q != S_IDLE, "accepted item did not start work")
  `ACC8_ASSERT_NOW(a_result_from_fin, $rose(m_axis_tvalid), $past(state_q) == S_FIN, "result raised outside final step")
  `ACC8_ASSERT_NOW(a_fetch_only_running, state_q == S_F_OP, !halt_q && !err_q, "fetch started on a stopped machine")

endmodule

[verif/acc8_result_checker.sv]
// result checker for the accumulator cpu: tracks the machine state and compares every result
module acc8_result_checker import acc8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // address[7:0], data[15:8]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // program_counter .. bad_opcode, see res_t
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          n_results_o,
  output int          n_fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  byte_t mem_copy [256];
  byte_t pc_copy;
  byte_t acc_copy;
  logic  halt_copy;
  logic  err_copy;
  byte_t start_copy;

  res_t  expected_results [$];
  res_t  want;
  res_t  got;
  int    results;
  int    fails;

  // run one instruction at pc_copy, in_byte is what an IN stores
  task automatic run_instruction(input byte_t in_byte, inout res_t r);
    byte_t opc, arg, nxt, dir, ind;
    logic  known;
    opc   = mem_copy[pc_copy];
    nxt   = pc_copy + 8'd1;
    arg   = mem_copy[nxt];
    nxt   = pc_copy + 8'd2;
    dir   = mem_copy[arg];
    ind   = mem_copy[dir];
    known = 1'b1;
    case (opc)
      OPC_JUMP:      nxt = arg;
      OPC_BRN:       if (acc_copy[7]) nxt = arg;
      OPC_BRZ:       if (acc_copy == 8'd0) nxt = arg;
      OPC_IN_DIR: begin
        mem_copy[arg] = in_byte;
        r.in_taken = 1'b1;
      end
      OPC_IN_IND: begin
        mem_copy[dir] = in_byte;
        r.in_taken = 1'b1;
      end
      OPC_OUT_DIR: begin
        r.out_valid = 1'b1;
        r.out_data  = dir;
      end
      OPC_OUT_IND: begin
        r.out_valid = 1'b1;
        r.out_data  = ind;
      end
      OPC_LOAD_IMM:  acc_copy = arg;
      OPC_LOAD_DIR:  acc_copy = dir;
      OPC_LOAD_IND:  acc_copy = ind;
      OPC_STORE_DIR: mem_copy[arg] = acc_copy;
      OPC_STORE_IND: mem_copy[dir] = acc_copy;
      OPC_ADD_IMM:   acc_copy = acc_copy + arg;
      OPC_ADD_DIR:   acc_copy = acc_copy + dir;
      OPC_ADD_IND:   acc_copy = acc_copy + ind;
      OPC_SUB_IMM:   acc_copy = acc_copy - arg;
      OPC_SUB_DIR:   acc_copy = acc_copy - dir;
      OPC_SUB_IND:   acc_copy = acc_copy - ind;
      OPC_NAND_IMM:  acc_copy = ~(acc_copy & arg);
      OPC_NAND_DIR:  acc_copy = ~(acc_copy & dir);
      OPC_NAND_IND:  acc_copy = ~(acc_copy & ind);
      default:       known = 1'b0;
    endcase
    // an unknown opcode leaves pc on the opcode byte
    if (known) begin
      pc_copy = nxt;
      if (pc_copy == 8'd0) halt_copy = 1'b1;
    end else begin
      err_copy = 1'b1;
    end
  endtask

  task automatic step_machine(input oper_e op, input byte_t addr, input byte_t data,
                              output res_t r);
    r = '0;
    case (op)
      OP_WRITE:   mem_copy[addr] = data;
      OP_READ:    r.read_data = mem_copy[addr];
      OP_RESTART: begin
        pc_copy   = start_copy;
        halt_copy = 1'b0;
        err_copy  = 1'b0;
      end
      default: if (!halt_copy && !err_copy) run_instruction(data, r);
    endcase
    r.program_counter = pc_copy;
    r.accumulator     = acc_copy;
    r.halted          = halt_copy;
    r.bad_opcode      = err_copy;
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mem_copy[i]) mem_copy[i] = '0;
      pc_copy    = '0;
      acc_copy   = '0;
      halt_copy  = 1'b0;
      err_copy   = 1'b0;
      start_copy = '0;
      expected_results.delete();
      results    = 0;
      fails      = 0;
    end else begin
      if (psel && penable && pready && paddr == {REG_START, 2'b00}) begin
        if (pwrite) begin
          start_copy = pwdata[7:0];
        end else if (prdata !== {24'd0, start_copy}) begin
          $error("start_address readback: expected %0h, got %0h", start_copy, prdata);
          fails++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_machine(oper_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8], want);
        expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[35:0]);
        results++;
        if (expected_results.size() == 0) begin
          $error("result item with no item waiting for it");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("program_counter", want.program_counter, got.program_counter);
          check_field("accumulator", want.accumulator, got.accumulator);
          check_field("read_data", want.read_data, got.read_data);
          check_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
          check_field("out_data", want.out_data, got.out_data);
          check_field("in_taken", 8'(want.in_taken), 8'(got.in_taken));
          check_field("halted", 8'(want.halted), 8'(got.halted));
          check_field("bad_opcode", 8'(want.bad_opcode), 8'(got.bad_opcode));
        end
      end
    end
    n_results_o <= results;
    n_fails_o   <= fails;
  end

endmodule

[verif/tb.sv]
// testbench top for the accumulator cpu: clock, reset, item and register stimulus, verdict
module tb import acc8_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldAtResult = 600;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 400;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // address[7:0], data[15:8]
  logic [1:0]  s_axis_tuser  = '0;  // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // program_counter[7:0], accumulator[15:8], read_data[23:16], out_valid[24],
  // out_data[32:25], in_taken[33], halted[34], bad_opcode[35], zeros[39:36]
  logic [39:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int          n_results;
  int          n_fails;
  int          n_sent        = 0;
  int unsigned quiet_cycles  = 0;
  bit          sender_burst  = 1'b0;
  byte_t       start_now     = '0;

  byte_t known_opcodes [21] = '{
    OPC_LOAD_IMM, OPC_LOAD_DIR, OPC_LOAD_IND, OPC_STORE_DIR, OPC_STORE_IND,
    OPC_ADD_IMM, OPC_ADD_DIR, OPC_ADD_IND, OPC_SUB_IMM, OPC_SUB_DIR, OPC_SUB_IND,
    OPC_NAND_IMM, OPC_NAND_DIR, OPC_NAND_IND, OPC_JUMP, OPC_BRN, OPC_BRZ,
    OPC_IN_DIR, OPC_IN_IND, OPC_OUT_DIR, OPC_OUT_IND
  };

  accumulator_cpu_8bit_step dut (.*);

  acc8_result_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .n_results_o (n_results),
    .n_fails_o   (n_fails)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, bursts of none, and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          burst;
    taken = 0;
    burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 15);
      if (taken == HoldAtResult) gap = HoldCycles;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  task automatic send_item(input oper_e op, input byte_t addr, input byte_t data);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // stop offering, let every result come back, then a few quiet cycles
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (n_results != n_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write start_address, then read it back
  task automatic write_start(input byte_t value);
    start_now = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_START, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic byte_t pick_opcode();
    if ($urandom_range(0, 15) == 0) return byte_t'($urandom);
    return known_opcodes[$urandom_range(0, 20)];
  endfunction

  // operands aim at the program itself, address zero, a small data pool, or anywhere
  function automatic byte_t pick_operand();
    case ($urandom_range(0, 3))
      0:       return byte_t'($urandom);
      1:       return start_now + byte_t'(2 * $urandom_range(0, 5));
      2:       return 8'h00;
      default: return 8'hE0 + byte_t'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic run_program();
    byte_t       at;
    int unsigned pick;
    at = start_now;
    if ($urandom_range(0, 7) == 0) begin
      // unstructured items
      repeat (8) send_item(oper_e'($urandom_range(0, 3)), byte_t'($urandom),
                           byte_t'($urandom));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      send_item(OP_WRITE, at, pick_opcode());
      send_item(OP_WRITE, at + 8'd1, pick_operand());
      at = at + 8'd2;
    end
    repeat ($urandom_range(0, 4)) send_item(OP_WRITE, 8'hE0 + byte_t'($urandom_range(0, 15)),
                                            byte_t'($urandom));
    send_item(OP_RESTART, byte_t'($urandom), byte_t'($urandom));
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(0, 19);
      if (pick < 2)        send_item(OP_READ, byte_t'($urandom), byte_t'($urandom));
      else if (pick == 2)  send_item(OP_WRITE, byte_t'($urandom), byte_t'($urandom));
      else if (pick == 3)  send_item(OP_RESTART, byte_t'($urandom), byte_t'($urandom));
      else                 send_item(OP_EXEC, byte_t'($urandom), byte_t'($urandom));
    end
  endtask

  initial begin
    byte_t phase_start;
    int    first_random;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_start(8'hFC);
    send_item(OP_READ, 8'hFF, 8'h00);          // never written, reads zero
    send_item(OP_WRITE, 8'hFC, OPC_SUB_IMM);
    send_item(OP_WRITE, 8'hFD, 8'h01);
    send_item(OP_WRITE, 8'hFE, OPC_BRZ);
    send_item(OP_WRITE, 8'hFF, 8'h20);
    send_item(OP_RESTART, 8'h00, 8'h00);
    send_item(OP_EXEC, 8'h00, 8'h00);          // acc wraps below zero
    send_item(OP_EXEC, 8'hFF, 8'h00);          // branch not taken, pc wraps to 0 and halts
    send_item(OP_EXEC, 8'h00, 8'hFF);          // halted, nothing moves
    send_item(OP_WRITE, 8'hFE, OPC_BRN);       // memory still works while halted
    send_item(OP_READ, 8'hFE, 8'hFF);
    send_item(OP_WRITE, 8'h20, 8'hFF);         // undefined opcode
    send_item(OP_RESTART, 8'hFF, 8'hFF);
    send_item(OP_EXEC, 8'h00, 8'h00);
    send_item(OP_EXEC, 8'h00, 8'h00);          // negative, branch taken
    send_item(OP_EXEC, 8'h00, 8'h00);          // error set, pc stays
    send_item(OP_EXEC, 8'h00, 8'h00);
    send_item(OP_RESTART, 8'h00, 8'h00);       // clears the error
    send_item(OP_WRITE, 8'h00, 8'h00);
    drain();

    first_random = n_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       phase_start = 8'h00;
        1:       phase_start = 8'hFF;
        2:       phase_start = 8'h80;
        default: phase_start = byte_t'($urandom);
      endcase
      write_start(phase_start);
      while (n_sent < first_random + int'(PhaseItems) * (ph + 1)) run_program();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (n_fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
